FILE: hdl/wra_pkg.sv
// shared types and constants for the wall running average filter
package wra_pkg;

    localparam int DATA_W    = 16;
    localparam int CFG_LEN_W = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0] COUNT_MAX = '1;

    typedef logic [DATA_W-1:0] t_word;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVG_LENGTH      = 3'd0,
        CFG_LOW_WALL_LIMIT  = 3'd1,
        CFG_HIGH_WALL_LIMIT = 3'd2,
        CFG_DROP_THRESHOLD  = 3'd3
    } t_cfg_idx;

    // divider status toward the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: hdl/wra_ram.sv
// generic single-port-write, single-port-read ram with registered read
module wra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/wra_div.sv
// restoring divider, one quotient bit per cycle
module wra_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output wra_pkg::t_div_stat    o_stat,
    output logic [NUM_W-1:0]      o_quo
);

    import wra_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

FILE: hdl/wall_running_average_dropout.sv
// Wall-thickness moving average with dropout hold. A good reading is written
// into the sample ram, the L averaged entries (L is the effective averaging
// length) are read back in turn through the single ram read port, and the
// bit-serial divider divides their sum, SUM_W = 16 + clog2(RING_DEPTH + 1)
// bits wide, by L. A dropout reading skips the ram and the divider. Only one
// item is worked on at a time; the result register lets the next item in
// while a result still waits to be taken. The ring comes out of reset as all
// zeros through per-entry valid bits, so no clearing pass is needed.
// Configuration is accepted every cycle.
module wall_running_average_dropout #(
    parameter int RING_DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [wra_pkg::DATA_W-1:0]       i_wall_reading,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [wra_pkg::DATA_W-1:0]       o_average_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wra_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wra_pkg::DATA_W-1:0]       i_cfg_data
);

    import wra_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LEN_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
    localparam int SUM_W = DATA_W + $clog2(RING_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DRAIN,
        S_DIVGO,
        S_DIV,
        S_DONE
    } t_state;

    // configuration
    logic [CFG_LEN_W-1:0] r_avg_length;
    t_word                r_low_limit;
    t_word                r_high_limit;
    t_word                r_drop_thresh;

    // control and state
    t_state               r_state;
    logic [IDX_W-1:0]     r_widx;
    t_word                r_drop_cnt;
    t_word                r_held;
    logic [RING_DEPTH-1:0] r_valid;
    logic [IDX_W-1:0]     r_rd_addr;
    logic                 r_pend;
    logic                 r_pend_ok;
    logic [SUM_W-1:0]     r_sum;
    logic [LEN_W-1:0]     r_len;
    t_word                r_result;
    logic                 r_out_valid;
    t_word                r_out_data;

    logic [CMP_W-1:0]     w_len_cfg;
    logic [LEN_W-1:0]     w_len;
    logic                 w_in_accept;
    logic                 w_dropout;
    logic [IDX_W-1:0]     w_idx_wr;
    logic [LEN_W-1:0]     w_idx_inc;
    logic [IDX_W-1:0]     w_idx_next;
    t_word                w_cnt_next;
    logic                 w_ram_we;
    t_word                w_ram_rdata;
    logic [SUM_W-1:0]     w_num;
    logic                 w_div_start;
    t_div_stat            w_div_stat;
    logic [SUM_W-1:0]     w_div_quo;
    t_word                w_avg;

    // effective length: zero acts as one, clamp to the ring depth
    assign w_len_cfg = CMP_W'(r_avg_length);
    always_comb begin
        if (w_len_cfg == '0) begin
            w_len = LEN_W'(1);
        end else if (w_len_cfg > CMP_W'(RING_DEPTH)) begin
            w_len = LEN_W'(RING_DEPTH);
        end else begin
            w_len = LEN_W'(w_len_cfg);
        end
    end

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_dropout   = (i_wall_reading <= r_low_limit) || (i_wall_reading >= r_high_limit);

    // stale index after a shortened length goes back to entry zero
    assign w_idx_wr   = (LEN_W'(r_widx) >= w_len) ? '0 : r_widx;
    assign w_idx_inc  = LEN_W'(w_idx_wr) + LEN_W'(1);
    assign w_idx_next = (w_idx_inc >= w_len) ? '0 : IDX_W'(w_idx_inc);

    assign w_cnt_next = (r_drop_cnt != COUNT_MAX) ? r_drop_cnt + 1'b1 : r_drop_cnt;

    assign w_ram_we    = w_in_accept && !w_dropout;
    assign w_num       = r_sum + SUM_W'(r_len >> 1);
    assign w_div_start = (r_state == S_DIVGO);
    assign w_avg       = w_div_quo[DATA_W-1:0];

    wra_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_idx_wr),
        .i_wdata (i_wall_reading),
        .i_raddr (r_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    wra_div #(
        .NUM_W (SUM_W),
        .DEN_W (LEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_len),
        .o_stat  (w_div_stat),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_length  <= CFG_LEN_W'(8);
            r_low_limit   <= '0;
            r_high_limit  <= '1;
            r_drop_thresh <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AVG_LENGTH:      r_avg_length  <= i_cfg_data[CFG_LEN_W-1:0];
                CFG_LOW_WALL_LIMIT:  r_low_limit   <= i_cfg_data;
                CFG_HIGH_WALL_LIMIT: r_high_limit  <= i_cfg_data;
                CFG_DROP_THRESHOLD:  r_drop_thresh <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_drop_cnt  <= '0;
            r_held      <= '0;
            r_valid     <= '0;
            r_rd_addr   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_pend) begin
                r_sum <= r_sum + (r_pend_ok ? SUM_W'(w_ram_rdata) : '0);
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        if (w_dropout) begin
                            r_drop_cnt <= w_cnt_next;
                            if (w_cnt_next > r_drop_thresh) begin
                                r_held   <= '0;
                                r_result <= '0;
                            end else begin
                                r_result <= r_held;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_drop_cnt        <= '0;
                            r_valid[w_idx_wr] <= 1'b1;
                            r_widx            <= w_idx_next;
                            r_len             <= w_len;
                            r_sum             <= '0;
                            r_rd_addr         <= '0;
                            r_state           <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    // one ram read per cycle, summed in the following cycle
                    r_pend    <= 1'b1;
                    r_pend_ok <= r_valid[r_rd_addr];
                    r_rd_addr <= r_rd_addr + 1'b1;
                    if (r_rd_addr == IDX_W'(r_len - 1'b1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        if (w_avg > r_high_limit) begin
                            // average above the high wall limit: empty the ring
                            r_valid  <= '0;
                            r_widx   <= '0;
                            r_sum    <= '0;
                            r_held   <= '0;
                            r_result <= '0;
                        end else begin
                            r_held   <= w_avg;
                            r_result <= w_avg;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_data  <= r_result;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_average_out = r_out_data;
    assign o_cfg_ready   = 1'b1;

    // the divider is never restarted while still running
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    // a rounded average of 16-bit readings fits 16 bits
    a_quo_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (w_div_quo[SUM_W-1:DATA_W] == '0))
        else $error("average quotient wider than a reading");

    // the read sweep stays within the averaged entries
    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (LEN_W'(r_rd_addr) < r_len))
        else $error("ring read beyond averaging length");

endmodule
